@@ design/window_median_filter_assert.svh @@
// Assertion macros for the median filter RTL
`ifndef WINDOW_MEDIAN_FILTER_ASSERT_SVH
`define WINDOW_MEDIAN_FILTER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define WMF_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("window_median_filter assertion failed");

// next-cycle implication, disabled during reset
`define WMF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("window_median_filter assertion failed");

`endif

@@ design/wmf_pkg.sv @@
// Types and constants of the window median filter
package wmf_pkg;

    localparam int SAMPLE_W = 16;
    localparam int MEDIAN_W = 17;
    localparam int COUNT_W  = 5;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } wmf_sample_t;

    typedef struct packed {
        logic signed [MEDIAN_W-1:0] median_doubled;
        logic [COUNT_W-1:0]         sample_count;
        logic                       overflowed;
    } wmf_result_t;

    typedef enum logic [2:0] {
        WMF_IDLE,
        WMF_CAND,
        WMF_CLOAD,
        WMF_SCAN,
        WMF_DONE
    } wmf_state_t;

endpackage

@@ design/wmf_store.sv @@
// Window sample memory: one write port, one registered read port
module wmf_store #(
    parameter int MAX_WINDOW = 16,
    parameter int ADDR_W     = 4
) (
    input  logic                                aclk,
    input  logic                                wr_en,
    input  logic [ADDR_W-1:0]                   wr_addr,
    input  logic signed [wmf_pkg::SAMPLE_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]                   rd_addr,
    output logic signed [wmf_pkg::SAMPLE_W-1:0] rd_data
);
    import wmf_pkg::*;

    logic signed [SAMPLE_W-1:0] mem_reg [MAX_WINDOW];
    logic signed [SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/wmf_select.sv @@
// Rank-counting median selector over the sample memory
module wmf_select #(
    parameter int MAX_WINDOW = 16,
    parameter int CNT_W      = 5,
    parameter int ADDR_W     = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [CNT_W-1:0]                    start_count,
    input  logic                                start_drop,
    output logic                                busy,
    output logic [ADDR_W-1:0]                   rd_addr,
    input  logic signed [wmf_pkg::SAMPLE_W-1:0] rd_data,
    output logic                                res_valid,
    input  logic                                res_ready,
    output wmf_pkg::wmf_result_t                res_data
);
    import wmf_pkg::*;

    wmf_state_t                 state_reg, state_next;
    logic [CNT_W-1:0]           n_reg, n_next;
    logic                       drop_reg, drop_next;
    logic [CNT_W-1:0]           hi_rank_reg, hi_rank_next;
    logic [CNT_W-1:0]           lo_rank_reg, lo_rank_next;
    logic [CNT_W-1:0]           i_reg, i_next;
    logic [CNT_W-1:0]           j_reg, j_next;
    logic [CNT_W-1:0]           rank_reg, rank_next;
    logic                       pend_reg, pend_next;
    logic [CNT_W-1:0]           pend_idx_reg, pend_idx_next;
    logic signed [SAMPLE_W-1:0] cand_reg, cand_next;
    logic signed [SAMPLE_W-1:0] lo_reg, lo_next;
    logic signed [SAMPLE_W-1:0] hi_reg, hi_next;
    logic [CNT_W-1:0]           rd_idx;
    logic                       less;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= WMF_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg        <= n_next;
        drop_reg     <= drop_next;
        hi_rank_reg  <= hi_rank_next;
        lo_rank_reg  <= lo_rank_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        rank_reg     <= rank_next;
        pend_reg     <= pend_next;
        pend_idx_reg <= pend_idx_next;
        cand_reg     <= cand_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
    end

    assign less = (rd_data < cand_reg) || ((rd_data == cand_reg) && (pend_idx_reg < i_reg));

    always_comb begin
        state_next    = state_reg;
        n_next        = n_reg;
        drop_next     = drop_reg;
        hi_rank_next  = hi_rank_reg;
        lo_rank_next  = lo_rank_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        rank_next     = rank_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        cand_next     = cand_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        rd_idx        = j_reg;
        res_valid     = 1'b0;

        case (state_reg)
            WMF_IDLE: begin
                if (start) begin
                    n_next       = start_count;
                    drop_next    = start_drop;
                    hi_rank_next = start_count >> 1;
                    lo_rank_next = start_count[0] ? (start_count >> 1)
                                                  : (start_count >> 1) - CNT_W'(1);
                    i_next       = '0;
                    state_next   = WMF_CAND;
                end
            end
            WMF_CAND: begin
                rd_idx     = i_reg;
                state_next = WMF_CLOAD;
            end
            WMF_CLOAD: begin
                cand_next     = rd_data;
                rd_idx        = '0;
                j_next        = CNT_W'(1);
                pend_next     = 1'b1;
                pend_idx_next = '0;
                rank_next     = '0;
                state_next    = WMF_SCAN;
            end
            WMF_SCAN: begin
                if (pend_reg) begin
                    rank_next = rank_reg + CNT_W'(less);
                    if (j_reg < n_reg) begin
                        rd_idx        = j_reg;
                        j_next        = j_reg + CNT_W'(1);
                        pend_idx_next = j_reg;
                    end else begin
                        pend_next = 1'b0;
                    end
                end else begin
                    if (rank_reg == hi_rank_reg) begin
                        hi_next = cand_reg;
                    end
                    if (rank_reg == lo_rank_reg) begin
                        lo_next = cand_reg;
                    end
                    i_next = i_reg + CNT_W'(1);
                    if (i_reg == n_reg - CNT_W'(1)) begin
                        state_next = WMF_DONE;
                    end else begin
                        state_next = WMF_CAND;
                    end
                end
            end
            WMF_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = WMF_IDLE;
                end
            end
            default: begin
                state_next = WMF_IDLE;
            end
        endcase
    end

    assign rd_addr = rd_idx[ADDR_W-1:0];
    assign busy    = (state_reg != WMF_IDLE);

    assign res_data.median_doubled = {lo_reg[SAMPLE_W-1], lo_reg}
                                   + {hi_reg[SAMPLE_W-1], hi_reg};
    assign res_data.sample_count   = COUNT_W'(n_reg);
    assign res_data.overflowed     = drop_reg;

endmodule

@@ design/window_median_filter.sv @@
// Window median filter top level: sample loading, selector and result register
//
//   Channel   Ports                        Payload
//   s_        s_valid, s_ready, s_data     wmf_sample_t (sample, last)
//   m_        m_valid, m_ready, m_data     wmf_result_t (median, count, flag)
//
// Samples load at one beat per cycle into the sample memory while the selector is idle.
// A last beat with n kept samples starts the selector, which ranks them by counting
// over the single memory read port; s_ready is low while it runs.
// The result sits in an output register; loading resumes while it waits.
// While the output register is full, a finished result holds and s_ready stays low.
// Reset (aresetn, synchronous) empties the window and the output register.
`include "window_median_filter_assert.svh"

module window_median_filter #(
    parameter int MAX_WINDOW = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  wmf_pkg::wmf_sample_t s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output wmf_pkg::wmf_result_t m_data
);
    import wmf_pkg::*;

    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int ADDR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    logic [CNT_W-1:0]           fill_count_reg, fill_count_next;
    logic                       drop_reg, drop_next;
    logic                       m_valid_reg, m_valid_next;
    wmf_result_t                m_data_reg, m_data_next;
    logic                       s_fire;
    logic                       has_room;
    logic                       sel_start;
    logic [CNT_W-1:0]           sel_count;
    logic                       sel_drop;
    logic                       sel_busy;
    logic [ADDR_W-1:0]          rd_addr;
    logic signed [SAMPLE_W-1:0] rd_data;
    logic                       res_valid;
    logic                       res_ready;
    wmf_result_t                res_data;

    assign s_ready   = !sel_busy;
    assign s_fire    = s_valid && s_ready;
    assign has_room  = (fill_count_reg < CNT_W'(MAX_WINDOW));
    assign sel_start = s_fire && s_data.last;
    assign sel_count = has_room ? fill_count_reg + CNT_W'(1) : fill_count_reg;
    assign sel_drop  = drop_reg || !has_room;
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        fill_count_next = fill_count_reg;
        drop_next       = drop_reg;
        if (s_fire) begin
            if (s_data.last) begin
                fill_count_next = '0;
                drop_next       = 1'b0;
            end else if (has_room) begin
                fill_count_next = fill_count_reg + CNT_W'(1);
            end else begin
                drop_next = 1'b1;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_data_next  = res_data;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_count_reg <= '0;
            drop_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            fill_count_reg <= fill_count_next;
            drop_reg       <= drop_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    wmf_store #(
        .MAX_WINDOW (MAX_WINDOW),
        .ADDR_W     (ADDR_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (s_fire && has_room),
        .wr_addr (fill_count_reg[ADDR_W-1:0]),
        .wr_data (s_data.sample),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    wmf_select #(
        .MAX_WINDOW (MAX_WINDOW),
        .CNT_W      (CNT_W),
        .ADDR_W     (ADDR_W)
    ) u_select (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (sel_start),
        .start_count (sel_count),
        .start_drop  (sel_drop),
        .busy        (sel_busy),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_data    (res_data)
    );

    `WMF_ASSERT_IMPL(a_fill_bound, aclk, aresetn, 1'b1, fill_count_reg <= CNT_W'(MAX_WINDOW))
    `WMF_ASSERT_NEXT(a_window_clear, aclk, aresetn, sel_start, fill_count_reg == '0 && !drop_reg)
    `WMF_ASSERT_NEXT(a_load_stall, aclk, aresetn, sel_start, !s_ready)

endmodule

@@ dv/tb_window_median_filter.sv @@
// Self-checking testbench: random-stall stream of sample windows, median predicted per window
module tb_window_median_filter;
    import wmf_pkg::*;

    localparam int WINDOW_DEPTH = 16;
    localparam int ITEM_TARGET  = 1650;
    localparam int SETTLE_CYCLES = 400;
    localparam int HOLDOFF_CYCLES = 700;
    localparam int HOLDOFF_AT_BEAT = 300;
    localparam int CALM_FIRST_BEAT = 900;
    localparam int CALM_LAST_BEAT  = 1200;
    localparam int IDLE_PERCENT = 8;
    localparam int REPORT_LIMIT = 10;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    wmf_sample_t s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    wmf_result_t m_data;

    wmf_sample_t pending_beats[$];
    wmf_result_t medians_due[$];

    logic signed [SAMPLE_W-1:0] window_samples[WINDOW_DEPTH];
    int   window_fill = 0;
    logic window_dropped = 1'b0;

    int   beats_taken = 0;
    int   fault_count = 0;
    int   holdoff_left = 0;
    logic holdoff_done = 1'b0;
    logic calm;

    window_median_filter #(.MAX_WINDOW(WINDOW_DEPTH)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #6 aclk = ~aclk;

    assign calm = (beats_taken >= CALM_FIRST_BEAT) && (beats_taken < CALM_LAST_BEAT);

    task automatic absorb_sample(input wmf_sample_t beat);
        int sorted_vals[WINDOW_DEPTH];
        int key;
        int i;
        int j;
        int med2;
        wmf_result_t due;
        if (window_fill < WINDOW_DEPTH) begin
            window_samples[window_fill] = beat.sample;
            window_fill++;
        end else begin
            window_dropped = 1'b1;
        end
        if (beat.last) begin
            for (i = 0; i < window_fill; i++) begin
                sorted_vals[i] = window_samples[i];
            end
            for (i = 1; i < window_fill; i++) begin
                key = sorted_vals[i];
                j = i;
                while (j > 0 && sorted_vals[j-1] > key) begin
                    sorted_vals[j] = sorted_vals[j-1];
                    j--;
                end
                sorted_vals[j] = key;
            end
            if (window_fill % 2 == 0) begin
                med2 = sorted_vals[window_fill/2 - 1] + sorted_vals[window_fill/2];
            end else begin
                med2 = 2 * sorted_vals[window_fill/2];
            end
            due.median_doubled = med2[MEDIAN_W-1:0];
            due.sample_count   = window_fill[COUNT_W-1:0];
            due.overflowed     = window_dropped;
            medians_due.push_back(due);
            window_fill = 0;
            window_dropped = 1'b0;
        end
    endtask

    task automatic check_median(input wmf_result_t got);
        wmf_result_t want;
        if (medians_due.size() == 0) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT) begin
                $display("unexpected result: median %0d count %0d flag %0d",
                         got.median_doubled, got.sample_count, got.overflowed);
            end
        end else begin
            want = medians_due.pop_front();
            if (got.median_doubled !== want.median_doubled ||
                got.sample_count !== want.sample_count ||
                got.overflowed !== want.overflowed) begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT) begin
                    $display("mismatch: expected median %0d count %0d flag %0d, got %0d %0d %0d",
                             want.median_doubled, want.sample_count, want.overflowed,
                             got.median_doubled, got.sample_count, got.overflowed);
                end
            end
        end
    endtask

    task automatic queue_beat(input logic signed [SAMPLE_W-1:0] value, input logic is_last);
        wmf_sample_t beat;
        beat.sample = value;
        beat.last   = is_last;
        pending_beats.push_back(beat);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int style;
        style = $urandom_range(5);
        case (style)
            0: begin
                return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            end
            1, 2: begin
                return SAMPLE_W'($signed($urandom_range(8)) - 4);
            end
            default: begin
                return SAMPLE_W'($urandom_range(16'hFFFF));
            end
        endcase
    endfunction

    task automatic queue_random_window();
        int len;
        int k;
        if ($urandom_range(99) < 15) begin
            len = $urandom_range(WINDOW_DEPTH + 4, WINDOW_DEPTH + 1);
        end else begin
            len = $urandom_range(WINDOW_DEPTH, 1);
        end
        for (k = 0; k < len; k++) begin
            queue_beat(pick_sample(), k == len - 1);
        end
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_beats.size() > 0 && (calm || $urandom_range(99) >= IDLE_PERCENT)) begin
                s_data  <= pending_beats.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // input monitor and predictor
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            absorb_sample(s_data);
            beats_taken <= beats_taken + 1;
        end
    end

    // receiver ready, with one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (holdoff_left > 0) begin
            m_ready <= 1'b0;
            holdoff_left <= holdoff_left - 1;
        end else if (!holdoff_done && beats_taken >= HOLDOFF_AT_BEAT) begin
            m_ready <= 1'b0;
            holdoff_left <= HOLDOFF_CYCLES;
            holdoff_done <= 1'b1;
        end else begin
            m_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // output monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            check_median(m_data);
        end
    end

    initial begin
        int k;
        queue_beat(16'sh7FFF, 1'b1);
        queue_beat(16'sh8000, 1'b1);
        queue_beat(16'sh7FFF, 1'b0);
        queue_beat(16'sh7FFF, 1'b1);
        queue_beat(16'sh8000, 1'b0);
        queue_beat(16'sh8000, 1'b1);
        queue_beat(16'sh7FFF, 1'b0);
        queue_beat(16'sh8000, 1'b0);
        queue_beat(16'sh7FFF, 1'b1);
        for (k = 0; k <= WINDOW_DEPTH; k++) begin
            queue_beat(SAMPLE_W'(k * 4099), k == WINDOW_DEPTH);
        end
        while (pending_beats.size() < ITEM_TARGET) begin
            queue_random_window();
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_beats.size() != 0 || s_valid) @(posedge aclk);
        while (medians_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fault_count == 0 && medians_due.size() == 0) begin
            $display("[window_median_filter] OK");
        end else begin
            $display("[window_median_filter] ERROR");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("[window_median_filter] ERROR");
        $finish;
    end

endmodule
